// ===== src/dsf_pkg.sv =====
// Shared types and constants for the damped spring force pipeline.
`timescale 1ns / 1ps
package dsf_pkg;

  localparam int SQRT_STAGES = 32;   // one result bit of the length per stage
  localparam int DIV_STAGES  = 31;   // one quotient bit of the direction per stage
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = CFG_IDX_W'(1);

  localparam logic [30:0] STIFFNESS_RESET = 31'd6553600;
  localparam logic [30:0] DAMPING_RESET   = 31'd6554;

  typedef struct packed {
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic [30:0]        rest_length;
    logic               last_in;
  } spring_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               zero_length;
    logic               last_out;
  } result_t;

  // Sideband carried through the length unit
  typedef struct packed {
    spring_t          spring;
    logic [2:0][31:0] mag;     // |delta| per axis
    logic             zero;
  } len_side_t;

  typedef struct packed {
    len_side_t   side;
    logic [31:0] len;          // Q16.16 length, floor of sqrt
  } len_out_t;

  typedef struct packed {
    len_out_t         base;
    logic [2:0][30:0] q;       // |d| per axis, Q1.30
  } quot_t;

endpackage

// ===== src/dsf_len.sv =====
// Length unit: per-axis squares, sum, and a 32-stage integer square root.
`timescale 1ns / 1ps
module dsf_len (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  dsf_pkg::spring_t   in_data,
  output logic               out_valid,
  output dsf_pkg::len_out_t  out_data
);
  import dsf_pkg::*;

  logic signed [31:0] delta [3];
  logic [2:0][31:0]   mag_in;

  logic               a_valid;
  len_side_t          a_side;
  logic               b_valid;
  len_side_t          b_side;
  logic [2:0][62:0]   b_sqr;

  logic               sq_valid [SQRT_STAGES+1];
  logic [63:0]        sq_n     [SQRT_STAGES+1];
  logic [63:0]        sq_r     [SQRT_STAGES+1];
  len_side_t          sq_side  [SQRT_STAGES+1];

  always_comb begin
    delta[0] = in_data.delta_x;
    delta[1] = in_data.delta_y;
    delta[2] = in_data.delta_z;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = delta[i][31] ? 32'(-delta[i]) : 32'(delta[i]);
    end
  end

  // A: magnitudes, B: squares, then the sum seeds the root
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      sq_valid[0] <= b_valid;
    end
    if (adv) begin
      a_side.spring <= in_data;
      a_side.mag    <= mag_in;
      a_side.zero   <= (in_data.delta_x == 32'sd0) && (in_data.delta_y == 32'sd0) &&
                       (in_data.delta_z == 32'sd0);
      b_side        <= a_side;
      for (int i = 0; i < 3; i++) begin
        b_sqr[i] <= 63'(a_side.mag[i]) * 63'(a_side.mag[i]);
      end
      sq_n[0]    <= 64'(b_sqr[0]) + 64'(b_sqr[1]) + 64'(b_sqr[2]);
      sq_r[0]    <= 64'd0;
      sq_side[0] <= b_side;
    end
  end

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_root
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] trial;
    logic        take;

    assign trial = sq_r[j] + BIT;
    assign take  = sq_n[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[j+1] <= sq_valid[j];
      end
      if (adv) begin
        sq_n[j+1]    <= take ? sq_n[j] - trial : sq_n[j];
        sq_r[j+1]    <= take ? (sq_r[j] >> 1) + BIT : sq_r[j] >> 1;
        sq_side[j+1] <= sq_side[j];
      end
    end
  end

  assign out_valid     = sq_valid[SQRT_STAGES];
  assign out_data.side = sq_side[SQRT_STAGES];
  assign out_data.len  = sq_r[SQRT_STAGES][31:0];

endmodule

// ===== src/dsf_div.sv =====
// Direction unit: three restoring dividers, one quotient bit per stage.
`timescale 1ns / 1ps
module dsf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  dsf_pkg::len_out_t  in_data,
  output logic               out_valid,
  output dsf_pkg::quot_t     out_data
);
  import dsf_pkg::*;

  logic             dv_valid [DIV_STAGES+1];
  logic [2:0][32:0] dv_rem   [DIV_STAGES+1];
  logic [2:0][30:0] dv_q     [DIV_STAGES+1];
  len_out_t         dv_base  [DIV_STAGES+1];

  always_comb begin
    dv_valid[0] = in_valid;
    dv_base[0]  = in_data;
    dv_q[0]     = '0;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = {1'b0, in_data.side.mag[i]};
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [2:0][32:0] rem_s;
    logic [2:0][32:0] rem_nx;
    logic [2:0][30:0] q_nx;
    logic [32:0]      den;

    // first stage takes the integer bit, the rest shift in fraction bits
    always_comb begin
      den = {1'b0, dv_base[j].len};
      for (int i = 0; i < 3; i++) begin
        rem_s[i] = (j == 0) ? dv_rem[j][i] : {dv_rem[j][i][31:0], 1'b0};
        if (rem_s[i] >= den) begin
          rem_nx[i] = rem_s[i] - den;
          q_nx[i]   = {dv_q[j][i][29:0], 1'b1};
        end else begin
          rem_nx[i] = rem_s[i];
          q_nx[i]   = {dv_q[j][i][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[j+1] <= dv_valid[j];
      end
      if (adv) begin
        dv_rem[j+1]  <= rem_nx;
        dv_q[j+1]    <= q_nx;
        dv_base[j+1] <= dv_base[j];
      end
    end
  end

  assign out_valid     = dv_valid[DIV_STAGES];
  assign out_data.base = dv_base[DIV_STAGES];
  assign out_data.q    = dv_q[DIV_STAGES];

endmodule

// ===== src/dsf_force.sv =====
// Force unit: dot product, spring and damper terms, scaling and saturation.
`timescale 1ns / 1ps
module dsf_force (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [30:0]      stiffness,
  input  logic [30:0]      damping,
  input  logic             in_valid,
  input  dsf_pkg::quot_t   in_data,
  output logic             out_valid,
  output dsf_pkg::result_t out_data
);
  import dsf_pkg::*;

  localparam int NST = 11;

  logic [NST-1:0]     tv;
  logic [NST-1:0]     zl;
  logic [NST-1:0]     ll;
  logic [2:0][30:0]   dm_q [8];
  logic [2:0]         dn_q [8];

  logic [2:0]         dneg_in;
  logic signed [31:0] d_in  [3];
  logic signed [31:0] rv_in [3];
  logic [31:0]        l0_ext;
  logic               len_ge;

  logic signed [31:0] t0_d  [3];
  logic signed [31:0] t0_rv [3];
  logic [31:0]        t0_emag;
  logic               t0_eneg;

  logic signed [63:0] t1_p [3];
  logic [62:0]        t1_kprod;
  logic               t1_eneg;

  logic signed [63:0] t2_dsum;
  logic [46:0]        t2_kext;
  logic               t2_eneg;

  logic [63:0]        vabs;
  logic [32:0]        t3_vmag;
  logic               t3_vneg;
  logic [46:0]        t3_kext;
  logic               t3_eneg;

  logic [63:0]        t4_cprod;
  logic               t4_vneg;
  logic [46:0]        t4_kext;
  logic               t4_eneg;

  logic signed [48:0] t5_ke;
  logic signed [48:0] t5_ce;

  logic [49:0]        t6_fsum;
  logic [49:0]        fneg_val;

  logic [48:0]        t7_fabs;
  logic               t7_fneg;

  logic [47:0]        t8_phi  [3];
  logic [62:0]        t8_plo  [3];
  logic [2:0]         t8_rneg;

  logic [50:0]        t9_rmag [3];
  logic [2:0]         t9_rneg;

  logic [31:0]        fsat [3];
  result_t            t10_res;

  always_comb begin
    dneg_in  = {in_data.base.side.spring.delta_z[31], in_data.base.side.spring.delta_y[31],
                in_data.base.side.spring.delta_x[31]};
    rv_in[0] = in_data.base.side.spring.rel_vel_x;
    rv_in[1] = in_data.base.side.spring.rel_vel_y;
    rv_in[2] = in_data.base.side.spring.rel_vel_z;
    for (int i = 0; i < 3; i++) begin
      d_in[i] = dneg_in[i] ? -$signed({1'b0, in_data.q[i]}) : $signed({1'b0, in_data.q[i]});
    end
    l0_ext = {1'b0, in_data.base.side.spring.rest_length};
    len_ge = in_data.base.len >= l0_ext;
  end

  assign vabs     = t2_dsum[63] ? 64'(-t2_dsum) : 64'(t2_dsum);
  assign fneg_val = -t6_fsum;

  // saturate to the signed 32-bit range; zero length forces zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zl[9]) begin
        fsat[i] = 32'd0;
      end else if (t9_rneg[i]) begin
        fsat[i] = (t9_rmag[i] >= 51'h80000000) ? 32'h80000000 : ~t9_rmag[i][31:0] + 32'd1;
      end else begin
        fsat[i] = (t9_rmag[i] > 51'h7FFFFFFF) ? 32'h7FFFFFFF : t9_rmag[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else if (adv) begin
      tv <= {tv[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zl <= {zl[NST-2:0], in_data.base.side.zero};
      ll <= {ll[NST-2:0], in_data.base.side.spring.last_in};
      dm_q[0] <= in_data.q;
      dn_q[0] <= dneg_in;
      for (int s = 1; s < 8; s++) begin
        dm_q[s] <= dm_q[s-1];
        dn_q[s] <= dn_q[s-1];
      end

      // T0: signed direction, extension l - l0 as sign and magnitude
      for (int i = 0; i < 3; i++) begin
        t0_d[i]  <= d_in[i];
        t0_rv[i] <= rv_in[i];
      end
      t0_emag <= len_ge ? in_data.base.len - l0_ext : l0_ext - in_data.base.len;
      t0_eneg <= !len_ge;

      // T1: dot product terms, k * |l - l0|
      for (int i = 0; i < 3; i++) begin
        t1_p[i] <= 64'(t0_rv[i]) * 64'(t0_d[i]);
      end
      t1_kprod <= 63'(t0_emag) * 63'(stiffness);
      t1_eneg  <= t0_eneg;

      // T2
      t2_dsum <= t1_p[0] + t1_p[1] + t1_p[2];
      t2_kext <= t1_kprod[62:16];
      t2_eneg <= t1_eneg;

      // T3: dot product truncated toward zero to Q16.16
      t3_vmag <= vabs[62:30];
      t3_vneg <= t2_dsum[63];
      t3_kext <= t2_kext;
      t3_eneg <= t2_eneg;

      // T4: c * |dot|
      t4_cprod <= 64'(t3_vmag) * 64'(damping);
      t4_vneg  <= t3_vneg;
      t4_kext  <= t3_kext;
      t4_eneg  <= t3_eneg;

      // T5: restore signs
      t5_ce <= t4_vneg ? -$signed({1'b0, t4_cprod[63:16]}) : $signed({1'b0, t4_cprod[63:16]});
      t5_ke <= t4_eneg ? -$signed({2'b00, t4_kext}) : $signed({2'b00, t4_kext});

      // T6: scalar force
      t6_fsum <= {t5_ke[48], t5_ke} + {t5_ce[48], t5_ce};

      // T7
      t7_fabs <= t6_fsum[49] ? fneg_val[48:0] : t6_fsum[48:0];
      t7_fneg <= t6_fsum[49];

      // T8: |f| * |d| as two partial products
      for (int i = 0; i < 3; i++) begin
        t8_phi[i]  <= 48'(t7_fabs[48:32]) * 48'(dm_q[7][i]);
        t8_plo[i]  <= 63'(t7_fabs[31:0]) * 63'(dm_q[7][i]);
        t8_rneg[i] <= t7_fneg ^ dn_q[7][i];
      end

      // T9: combine, scaled by 2^-30
      for (int i = 0; i < 3; i++) begin
        t9_rmag[i] <= 51'({t8_phi[i], 2'b00}) + 51'(t8_plo[i][62:30]);
      end
      t9_rneg <= t8_rneg;

      // T10
      t10_res.force_x     <= fsat[0];
      t10_res.force_y     <= fsat[1];
      t10_res.force_z     <= fsat[2];
      t10_res.zero_length <= zl[9];
      t10_res.last_out    <= ll[9];
    end
  end

  assign out_valid = tv[NST-1];
  assign out_data  = t10_res;

endmodule

// ===== src/damped_spring_force_top.sv =====
// Top level of the damped spring force pipeline: registers, units, output buffer.
`timescale 1ns / 1ps
// Path from an accepted spring to result_valid when nothing stalls: the length unit,
// the direction unit, the force unit, then the output register.
// Throughput: one spring per clock while the skid is empty; the 32-stage root and
// 31-stage divider set the depth. On a held result the skid takes the item in flight.
// Reset (rst, synchronous): pipeline empty, stiffness 100.0, damping about 0.1.
module damped_spring_force_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           spring_valid,
  output logic                           spring_ready,
  input  dsf_pkg::spring_t               spring_data,
  output logic                           result_valid,
  input  logic                           result_ready,
  output dsf_pkg::result_t               result_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import dsf_pkg::*;

  logic [30:0] stiffness;
  logic [30:0] damping;

  // whole pipeline advances together; it holds only while the skid is occupied
  logic        adv;
  logic        len_valid;
  len_out_t    len_data;
  logic        quot_valid;
  quot_t       quot_data;
  logic        tail_valid;
  result_t     tail_data;

  logic        skid_valid;
  result_t     skid_data;
  logic        take;

  assign adv          = !skid_valid;
  assign spring_ready = adv;
  assign cfg_ready    = 1'b1;
  assign take         = result_valid && result_ready;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFFNESS_RESET;
      damping   <= DAMPING_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STIFFNESS: stiffness <= cfg_data[30:0];
        CFG_DAMPING:   damping   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  dsf_len u_len (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (spring_valid),
    .in_data   (spring_data),
    .out_valid (len_valid),
    .out_data  (len_data)
  );

  dsf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (len_valid),
    .in_data   (len_data),
    .out_valid (quot_valid),
    .out_data  (quot_data)
  );

  dsf_force u_force (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .stiffness (stiffness),
    .damping   (damping),
    .in_valid  (quot_valid),
    .in_data   (quot_data),
    .out_valid (tail_valid),
    .out_data  (tail_data)
  );

  // Output register plus one skid entry. A transaction leaving the pipeline goes
  // to the output register when it is free or being emptied, else to the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (adv && tail_valid) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_valid) begin
      if (!result_valid || take) begin
        result_data <= tail_data;
      end else begin
        skid_data <= tail_data;
      end
    end else if (take && skid_valid) begin
      result_data <= skid_data;
    end
  end

  // The skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a transaction with the output register empty");

  // Input is refused only while a result is pending
  a_ready_only_blocked: assert property (@(posedge clk) disable iff (rst)
    !spring_ready |-> result_valid)
    else $error("input stalled with no pending result");

  // Zero-length springs carry no force
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.zero_length) |->
      (result_data.force_x == 32'sd0 && result_data.force_y == 32'sd0 &&
       result_data.force_z == 32'sd0))
    else $error("zero-length spring with nonzero force");

  // A full skid drains into the output register once the result is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && take) |=> (result_valid && !skid_valid))
    else $error("skid failed to drain");

endmodule
